[sv/htc_pkg.sv]
// Package for the humidity/temperature conversion block: widths, beat types,
// fixed-point constants and the clamp codes. No dependencies.
package htc_pkg;

    localparam int OFFS_W = 13;   // temperature offset register
    localparam int RAWT_W = 14;   // raw temperature count
    localparam int RAWH_W = 12;   // raw humidity count
    localparam int TEMP_W = 15;   // temperature, centi-degrees
    localparam int HUM_W  = 14;   // humidity, centi-percent
    localparam int FLAG_W = 2;
    localparam int TSUM_W = 16;   // offset + count before saturation
    localparam int A_W    = 16;   // 1000 + 8*rh
    localparam int P1_W   = 41;
    localparam int P2_W   = 38;
    localparam int P3_W   = 33;
    localparam int X_W    = 44;   // RH in units of 1e-10 %RH
    localparam int Z_W    = 32;   // (x + half a centi) >> 8
    localparam int Q_W    = 14;

    localparam logic signed [OFFS_W-1:0] OFFS_RESET = -13'sd3970;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 15'sd16383;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -15'sd16384;
    localparam logic signed [TSUM_W-1:0] TEMP_REF   = 16'sd2500;

    // RH = C1 + C2*rh - C3*rh^2 + (tc - 2500)*(1000 + 8*rh)*1000, in 1e-10 %RH
    localparam logic signed [X_W-1:0] RH_C1    = -44'sd20468000000;
    localparam logic [28:0]           RH_C2    = 29'd367000000;
    localparam logic [13:0]           RH_C3    = 14'd15955;
    localparam logic [9:0]            RH_TBASE = 10'd1000;
    localparam logic signed [X_W-1:0] RH_TSCL  = 44'sd1000;
    localparam logic signed [X_W-1:0] X_HI     = 44'sd1000000000000; // 100 %
    localparam logic signed [X_W-1:0] X_LO     = 44'sd1000000000;    // 0.1 %
    localparam logic signed [X_W-1:0] X_HALF   = 44'sd50000000;      // half a centi

    // 1e8 = 256 * 390625; quotient by reciprocal then one correction step
    localparam logic [18:0] DIV_D     = 19'd390625;
    localparam logic [13:0] DIV_RECIP = 14'd10995;    // floor(2^32 / 390625)

    localparam logic [HUM_W-1:0] HUM_MAX = 14'd10000;
    localparam logic [HUM_W-1:0] HUM_MIN = 14'd10;

    typedef enum logic [FLAG_W-1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } t_clamp;

    typedef struct packed {
        logic [RAWT_W-1:0] raw_temp;
        logic [RAWH_W-1:0] raw_humidity;
    } t_in_beat;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic [HUM_W-1:0]         humidity_centi;
        logic [FLAG_W-1:0]        clamp_flag;
    } t_out_beat;

    // after the products stage
    typedef struct packed {
        logic signed [TEMP_W-1:0] tc;
        logic [P1_W-1:0]          p1;
        logic [P2_W-1:0]          p2;
        logic signed [P3_W-1:0]   p3;
    } t_prod;

    // after the sum and clamp stage
    typedef struct packed {
        logic signed [TEMP_W-1:0] tc;
        t_clamp                   flag;
        logic [Z_W-1:0]           z;
    } t_frac;

endpackage

[sv/htc_if.sv]
// Valid/ready channel interfaces: sample input, result output, offset write.
// Depends on htc_pkg.
interface htc_in_if import htc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface htc_out_if import htc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface htc_cfg_if import htc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OFFS_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/htc_front.sv]
// Stages 1 and 2: saturated temperature, rh squared, then the three products.
// Depends on htc_pkg.
module htc_front import htc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [OFFS_W-1:0] i_temp_offset,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_in_beat                 i_beat,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_prod                    o_prod
);

    logic                     r_v1, r_v2;
    logic                     en1, en2;
    logic signed [TEMP_W-1:0] r_tc1;
    logic [RAWH_W-1:0]        r_rh1;
    logic [2*RAWH_W-1:0]      r_rh2;
    logic [A_W-1:0]           r_a1;
    t_prod                    r_prod;

    logic signed [TSUM_W-1:0] n_tsum;
    logic signed [TEMP_W-1:0] n_tc;
    logic [2*RAWH_W-1:0]      n_rh2;
    logic [A_W-1:0]           n_a;
    logic signed [TSUM_W-1:0] tdiff;
    t_prod                    n_prod;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_prod  = r_prod;

    // stage 1
    always_comb begin
        n_tsum = {{(TSUM_W-OFFS_W){i_temp_offset[OFFS_W-1]}}, i_temp_offset}
               + {{(TSUM_W-RAWT_W){1'b0}}, i_beat.raw_temp};
        if (n_tsum > TSUM_W'(TEMP_MAX)) begin
            n_tc = TEMP_MAX;
        end else if (n_tsum < TSUM_W'(TEMP_MIN)) begin
            n_tc = TEMP_MIN;
        end else begin
            n_tc = n_tsum[TEMP_W-1:0];
        end
        n_rh2 = (2*RAWH_W)'(i_beat.raw_humidity) * (2*RAWH_W)'(i_beat.raw_humidity);
        n_a   = A_W'(RH_TBASE) + {{(A_W-RAWH_W-3){1'b0}}, i_beat.raw_humidity, 3'b000};
    end

    // stage 2
    always_comb begin
        tdiff     = {r_tc1[TEMP_W-1], r_tc1} - TEMP_REF;
        n_prod.tc = r_tc1;
        n_prod.p1 = P1_W'(r_rh1) * P1_W'(RH_C2);
        n_prod.p2 = P2_W'(r_rh2) * P2_W'(RH_C3);
        n_prod.p3 = P3_W'(tdiff) * P3_W'(signed'({1'b0, r_a1}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_tc1 <= n_tc;
            r_rh1 <= i_beat.raw_humidity;
            r_rh2 <= n_rh2;
            r_a1  <= n_a;
        end
        if (en2 && r_v1) begin
            r_prod <= n_prod;
        end
    end

endmodule

[sv/htc_sum.sv]
// Stage 3: sums the products into exact RH, decides the clamp and pre-shifts
// the rounded value for the divider. Depends on htc_pkg.
module htc_sum import htc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_prod i_prod,
    output logic  o_valid,
    input  logic  i_ready,
    output t_frac o_frac
);

    logic               r_v;
    logic               en;
    t_frac              r_frac;
    logic signed [X_W-1:0] n_x;
    logic signed [X_W-1:0] n_y;
    t_frac              n_frac;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_frac  = r_frac;

    always_comb begin
        n_x = RH_C1 + signed'(X_W'(i_prod.p1)) - signed'(X_W'(i_prod.p2))
            + X_W'(i_prod.p3) * RH_TSCL;
        n_y = n_x + X_HALF;
        n_frac.tc = i_prod.tc;
        n_frac.z  = n_y[Z_W+7:8];   // 1e8 = 2^8 * 390625
        if (n_x > X_HI) begin
            n_frac.flag = CLAMP_HIGH;
        end else if (n_x < X_LO) begin
            n_frac.flag = CLAMP_LOW;
        end else begin
            n_frac.flag = CLAMP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_frac <= n_frac;
        end
    end

endmodule

[sv/htc_div.sv]
// Stages 4 and 5: divide by 390625 via reciprocal estimate and one correction,
// then select the clamped or rounded humidity. Depends on htc_pkg.
module htc_div import htc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_frac     i_frac,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_beat
);

    localparam int PROD_W = Z_W + Q_W;
    localparam int REM_W  = Z_W + 1;

    logic                     r_v4, r_v5;
    logic                     en4, en5;
    logic signed [TEMP_W-1:0] r_tc4;
    t_clamp                   r_flag4;
    logic [Z_W-1:0]           r_z4;
    logic [Q_W-1:0]           r_q0;
    t_out_beat                r_beat;

    logic [PROD_W-1:0]        n_prod;
    logic [REM_W-1:0]         n_sub;
    logic [REM_W-1:0]         n_rem;
    logic [Q_W-1:0]           n_q;
    t_out_beat                n_beat;

    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;
    assign o_valid = r_v5;
    assign o_beat  = r_beat;

    // estimate is the quotient or one short of it
    assign n_prod = PROD_W'(i_frac.z) * PROD_W'(DIV_RECIP);

    always_comb begin
        n_sub = REM_W'(r_q0) * REM_W'(DIV_D);
        n_rem = REM_W'(r_z4) - n_sub;
        n_q   = (n_rem >= REM_W'(DIV_D)) ? r_q0 + 1'b1 : r_q0;
        n_beat.temperature_centi = r_tc4;
        n_beat.clamp_flag        = r_flag4;
        case (r_flag4)
            CLAMP_HIGH: n_beat.humidity_centi = HUM_MAX;
            CLAMP_LOW:  n_beat.humidity_centi = HUM_MIN;
            default:    n_beat.humidity_centi = n_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_valid) begin
            r_tc4   <= i_frac.tc;
            r_flag4 <= i_frac.flag;
            r_z4    <= i_frac.z;
            r_q0    <= n_prod[PROD_W-1:Z_W];
        end
        if (en5 && r_v4) begin
            r_beat <= n_beat;
        end
    end

endmodule

[sv/humidity_temp_conversion_top.sv]
// Top level of the humidity/temperature conversion block.
// Depends on htc_pkg, htc_if, htc_front, htc_sum and htc_div.
//
// Usage
//   i_in  : one beat per sample pair (raw_temp, raw_humidity), valid/ready.
//   o_out : one beat per sample: temperature_centi, humidity_centi, clamp_flag.
//   i_cfg : writes the signed temperature offset; always ready. Write it only
//           while no sample is in flight.
// Timing
//   Five register stages: saturated temperature and rh^2, the three products,
//   exact sum with clamp decision, reciprocal quotient estimate, correction
//   and output register. Throughput is one beat per cycle while the output
//   is taken.
// Reset
//   All stages empty, offset back to -39.70 degrees.
// Back-pressure
//   Each stage has its own valid bit and holds while the next cannot take its beat, so
//   bubbles close up; input stays ready unless all five stages hold beats and
//   the output is not taken. Nothing is dropped or repeated.
module humidity_temp_conversion_top import htc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htc_in_if.sink     i_in,
    htc_out_if.source  o_out,
    htc_cfg_if.sink    i_cfg
);

    logic signed [OFFS_W-1:0] r_temp_offset;

    logic  prod_valid, prod_ready;
    t_prod prod;
    logic  frac_valid, frac_ready;
    t_frac frac;

    // offset register, written whenever a write beat arrives
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_offset <= OFFS_RESET;
        end else if (i_cfg.valid) begin
            r_temp_offset <= i_cfg.data;
        end
    end

    htc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_temp_offset (r_temp_offset),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_beat        (i_in.payload),
        .o_valid       (prod_valid),
        .i_ready       (prod_ready),
        .o_prod        (prod)
    );

    htc_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_prod  (prod),
        .o_valid (frac_valid),
        .i_ready (frac_ready),
        .o_frac  (frac)
    );

    htc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (frac_valid),
        .o_ready (frac_ready),
        .i_frac  (frac),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_beat  (o_out.payload)
    );

    // humidity always inside the clamp window
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.payload.humidity_centi >= HUM_MIN
                         && o_out.payload.humidity_centi <= HUM_MAX))
        else $error("humidity outside clamp window");

    // clamp codes agree with the value shown
    a_clamp_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.clamp_flag == CLAMP_HIGH)
        |-> o_out.payload.humidity_centi == HUM_MAX)
        else $error("high clamp without full-scale humidity");

    a_clamp_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.clamp_flag == CLAMP_LOW)
        |-> o_out.payload.humidity_centi == HUM_MIN)
        else $error("low clamp without minimum humidity");

    // with the output stage empty no stage can block the input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output stage");

endmodule
